/* rtl/core/mov_pkg.sv */
`timescale 1ns / 1ps
// mov_pkg: shared types for the median-of-merged-values block.
// No dependencies; used by median_of_merged_values_top.
package mov_pkg;

    localparam int VAL_W = 32;  // input value width
    localparam int SUM_W = 33;  // doubled median width
    localparam int TOT_W = 7;   // reported count width

    typedef struct packed {
        logic signed [VAL_W-1:0] item_value;
        logic                    last_item;
    } t_in_beat;

    typedef struct packed {
        logic signed [SUM_W-1:0] median_doubled;
        logic [TOT_W-1:0]        item_total;
        logic                    overflow_error;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,   // ready for an input beat
        S_INS,    // insertion walk: compare, shift up, place
        S_RD_A,   // read first middle entry
        S_RD_B,   // read second middle entry
        S_SUM     // form result, wait for output register
    } t_state;

endpackage

/* rtl/core/median_of_merged_values_top.sv */
`timescale 1ns / 1ps
// median_of_merged_values_top: streaming median over a bounded, sorted store.
// Depends on mov_pkg and mov_ram.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  input   | in  | i_valid / o_stall  | i_data  (item_value, last_item)
//  result  | out | o_valid / i_stall  | o_data  (median_doubled, item_total,
//          |     |                    |          overflow_error)
//
// Sequence: a stored beat is issued, then walks down past each stored value
//   larger than it (one RAM read/compare/write step per shifted entry) and is
//   placed. A dropped beat is not written to the store. A beat marked last
//   adds a median readout through the single RAM read port.
// Reset: synchronous, active low; clears count, overflow flag, state and o_valid.
//   The RAM needs no clearing: only entries written in the current set are read.
// Stalls: o_stall is high whenever the block is busy; a held result keeps the
//   block in its final step until i_stall drops.
module median_of_merged_values_top #(
    parameter int MAX_ITEMS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  mov_pkg::t_in_beat i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output mov_pkg::t_out_beat o_data
);
    import mov_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;  // store address
    localparam int CW = $clog2(MAX_ITEMS + 1);                    // fill count

    t_state r_state, n_state;

    // control
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_ovalid, n_ovalid;

    // payload / datapath
    logic signed [VAL_W-1:0] r_val, n_val;
    logic                    r_last, n_last;
    logic [CW-1:0]           r_pos, n_pos;     // slot the new value may land in
    logic signed [VAL_W-1:0] r_a, n_a;         // first middle value
    t_out_beat               r_out, n_out;

    // RAM port
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [VAL_W-1:0]        ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [VAL_W-1:0]        ram_rdata;

    logic                    in_acc;
    logic                    full;
    logic                    rd_gt;
    logic                    ins_done;
    logic                    out_load;
    logic [CW-1:0]           half;
    logic [CW-1:0]           pos_m1;
    logic [CW-1:0]           pos_m2;
    logic [CW-1:0]           cnt_m1;
    logic [CW+TOT_W-1:0]     cnt_ext;
    logic signed [SUM_W-1:0] sum_even;
    logic signed [SUM_W-1:0] sum_odd;

    mov_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign full     = (r_count == CW'(MAX_ITEMS));
    assign rd_gt    = $signed(ram_rdata) > r_val;
    // walk ends at slot zero or once the stored neighbor is not larger
    assign ins_done = (r_pos == '0) || !rd_gt;
    assign out_load = (r_state == S_SUM) && (!r_ovalid || !i_stall);
    assign half     = r_count >> 1;
    assign pos_m1   = r_pos - 1'b1;
    assign pos_m2   = r_pos - 2'd2;
    assign cnt_m1   = r_count - 1'b1;
    assign cnt_ext  = {{TOT_W{1'b0}}, r_count};

    // sum of the two middle values, sign-extended to stay exact
    assign sum_even = {r_a[VAL_W-1], r_a} + {ram_rdata[VAL_W-1], ram_rdata};
    assign sum_odd  = {r_a, 1'b0};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!full) begin
                        n_state = S_INS;
                    end else if (i_data.last_item) begin
                        n_state = S_RD_A;
                    end
                end
            end
            S_INS: begin
                if (ins_done) begin
                    n_state = r_last ? S_RD_A : S_IDLE;
                end
            end
            S_RD_A:  n_state = S_RD_B;
            S_RD_B:  n_state = S_SUM;
            S_SUM: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_val     = r_val;
        n_last    = r_last;
        n_pos     = r_pos;
        n_a       = r_a;
        n_out     = r_out;
        n_ovalid  = r_ovalid;
        ram_we    = 1'b0;
        ram_waddr = r_pos[AW-1:0];
        ram_wdata = r_val;
        ram_raddr = pos_m2[AW-1:0];

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                ram_raddr = cnt_m1[AW-1:0];
                if (in_acc) begin
                    n_val  = i_data.item_value;
                    n_last = i_data.last_item;
                    n_pos  = r_count;
                    if (full) begin
                        n_ovf = 1'b1;
                    end
                end
            end
            S_INS: begin
                ram_we = 1'b1;
                if (ins_done) begin
                    // place the new value
                    ram_wdata = r_val;
                    n_count   = r_count + 1'b1;
                end else begin
                    // shift the larger neighbor up, look one slot further down
                    ram_wdata = ram_rdata;
                    n_pos     = pos_m1;
                end
            end
            S_RD_A: begin
                ram_raddr = r_count[0] ? half[AW-1:0] : cnt_m1[AW-1:0] >> 1;
            end
            S_RD_B: begin
                n_a       = $signed(ram_rdata);
                ram_raddr = half[AW-1:0];
            end
            S_SUM: begin
                ram_raddr = half[AW-1:0];  // hold read data while the output waits
                if (out_load) begin
                    n_out.median_doubled = r_count[0] ? sum_odd : sum_even;
                    n_out.item_total     = cnt_ext[TOT_W-1:0];
                    n_out.overflow_error = r_ovf;
                    n_ovalid             = 1'b1;
                    n_count              = '0;
                    n_ovf                = 1'b0;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_last <= n_last;
        r_pos  <= n_pos;
        r_a    <= n_a;
        r_out  <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    // fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("store count beyond capacity");

    // insertion never writes past the current fill
    a_ins_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_pos <= r_count) && !full)
        else $error("insertion slot out of range");

    // a new result only appears out of the final readout step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_SUM))
        else $error("result raised outside readout");

    // the store is empty again once a result is loaded
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_count == '0) && !r_ovf)
        else $error("store not cleared after result");
`endif

endmodule

/* rtl/core/mov_ram.sv */
`timescale 1ns / 1ps
// mov_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mov_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
